FILE: rtl/dcht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcht_pkg
// Shared types and constants of the line container: stored line, cell
// commands, redundancy test words and result status codes.
// ----------------------------------------------------------------------------
package dcht_pkg;

  localparam int MAX_LINES_DEF = 64;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [32:0] slope;
    logic signed [32:0] icpt;
  } line_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROT,
    OP_INS,
    OP_DEL
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    line_t    line;
  } cell_cmd_t;

  // which test a redundancy word belongs to
  typedef enum logic [1:0] {
    TAG_LEFT,
    TAG_DOM,
    TAG_RIGHT
  } red_tag_t;

  // middle line b is tested between a (lower slope) and c (higher slope)
  typedef struct packed {
    logic     valid;
    red_tag_t tag;
    line_t    a;
    line_t    b;
    line_t    c;
  } red_iss_t;

  typedef struct packed {
    logic     valid;
    red_tag_t tag;
    logic     hit;
  } red_res_t;

endpackage

FILE: rtl/dcht_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcht_cell
// One table slot. Rotates toward cell 0, opens a gap for an insert or closes
// one for a delete, all under a common command.
// ----------------------------------------------------------------------------
module dcht_cell import dcht_pkg::*; #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_cmd_t     cmd,
  input  logic [IW-1:0] idx,
  input  line_t         left_in,
  input  line_t         right_in,
  output line_t         line_o
);

  localparam logic [IW-1:0] ME = IW'(IDX);

  line_t line_r;

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_HOLD: ;
      OP_ROT: line_r <= right_in;
      OP_INS: begin
        if (ME > idx) line_r <= left_in;
        else if (ME == idx) line_r <= cmd.line;
      end
      OP_DEL: begin
        if (ME >= idx) line_r <= right_in;
      end
    endcase
  end

  assign line_o = line_r;

endmodule

FILE: rtl/dcht_redund.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcht_redund
// Three-stage exact test whether middle line b is redundant between a and c:
// (ba-bc)*(mb-ma) <= (ba-bb)*(mc-ma).
// ----------------------------------------------------------------------------
module dcht_redund import dcht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  red_iss_t iss,
  output red_res_t res
);

  logic               v1_r, v2_r, hit_r, v3_r;
  red_tag_t           t1_r, t2_r, t3_r;
  logic signed [33:0] d1_r, d2_r, d3_r, d4_r;
  logic signed [67:0] pl_r, pr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= iss.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
    t1_r  <= iss.tag;
    d1_r  <= 34'(iss.a.icpt) - 34'(iss.c.icpt);
    d2_r  <= 34'(iss.b.slope) - 34'(iss.a.slope);
    d3_r  <= 34'(iss.a.icpt) - 34'(iss.b.icpt);
    d4_r  <= 34'(iss.c.slope) - 34'(iss.a.slope);
    t2_r  <= t1_r;
    pl_r  <= d1_r * d2_r;
    pr_r  <= d3_r * d4_r;
    t3_r  <= t2_r;
    hit_r <= (pl_r <= pr_r);
  end

  assign res.valid = v3_r;
  assign res.tag   = t3_r;
  assign res.hit   = hit_r;

endmodule

FILE: rtl/dynamic_convex_hull_trick_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_convex_hull_trick_unit
// Upper (or, in min mode, lower) envelope of lines kept in a ring of cells.
// ----------------------------------------------------------------------------
// One word is worked at a time. Every word starts with one full turn of the
// cell ring, during which the line at cell 0 feeds either the query
// evaluator or the redundancy test, then a pipeline drain. A query then
// finishes through the decide and response states. An insert makes one ring
// edit at a time (replacing an equal-slope line, placing the new line,
// each neighbor removed) plus bookkeeping. The next word is taken while a
// result still waits on the output.
// ----------------------------------------------------------------------------
module dynamic_convex_hull_trick_unit import dcht_pkg::*; #(
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_slope,
  input  logic signed [31:0] in_intercept,
  input  logic signed [31:0] in_query_x,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_value,
  output logic [1:0]         out_status
);

  localparam int IW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam logic [CW-1:0] NC   = CW'(MAX_LINES);
  localparam logic [IW-1:0] LAST = IW'(MAX_LINES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_DEL_L,
    S_DEL_R,
    S_RESP
  } state_t;

  state_t             state_r;
  logic               min_mode_r;
  logic               is_query_r;
  line_t              nline_r;
  logic signed [31:0] x_r;
  logic [IW-1:0]      scan_i_r;
  logic [1:0]         drain_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      p_r;
  logic [CW-1:0]      lrun_r;
  logic [CW-1:0]      rrun_r;
  logic [CW-1:0]      del_k_r;
  logic [IW-1:0]      e_r;
  logic               after_r, have_prev_r, skip_r, drop_r, dom_r, rbroken_r;
  line_t              prev_r;
  logic               qv1_r, qv2_r, have_best_r;
  logic signed [64:0] qprod_r;
  logic signed [32:0] qb1_r;
  logic signed [63:0] qy_r, best_r;
  logic               out_valid_r;
  logic signed [63:0] out_value_r, res_value_r;
  logic [1:0]         out_status_r, res_status_r;

  cell_cmd_t          cmd;
  logic [IW-1:0]      cidx;
  red_iss_t           iss;
  red_res_t           rres;
  line_t              head;
  logic               slot_ok, lt, eq;
  logic signed [32:0] m_ext, b_ext;
  line_t              cell_q [MAX_LINES];

  genvar gi;
  generate
    for (gi = 0; gi < MAX_LINES; gi++) begin : g_cell
      dcht_cell #(.IW(IW), .IDX(gi)) u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .idx      (cidx),
        .left_in  (cell_q[(gi + MAX_LINES - 1) % MAX_LINES]),
        .right_in (cell_q[(gi + 1) % MAX_LINES]),
        .line_o   (cell_q[gi])
      );
    end
  endgenerate

  dcht_redund u_red (
    .clk   (clk),
    .rst_n (rst_n),
    .iss   (iss),
    .res   (rres)
  );

  assign head    = cell_q[0];
  assign slot_ok = CW'(scan_i_r) < count_r;
  assign lt      = head.slope < nline_r.slope;
  assign eq      = head.slope == nline_r.slope;
  assign m_ext   = {in_slope[31], in_slope};
  assign b_ext   = {in_intercept[31], in_intercept};

  always_comb begin
    cmd.op   = OP_HOLD;
    cmd.line = nline_r;
    cidx     = '0;
    iss      = '0;
    unique case (state_r)
      S_SCAN: begin
        cmd.op = OP_ROT;
        if (slot_ok && !is_query_r && have_prev_r) begin
          if (after_r) begin
            iss = '{valid: 1'b1, tag: TAG_RIGHT, a: nline_r, b: prev_r, c: head};
          end else if (lt) begin
            iss = '{valid: 1'b1, tag: TAG_LEFT, a: prev_r, b: head, c: nline_r};
          end else if (!eq) begin
            iss = '{valid: 1'b1, tag: TAG_DOM, a: prev_r, b: nline_r, c: head};
          end
        end
      end
      S_DECIDE: begin
        if (!is_query_r && !drop_r) begin
          if (skip_r) begin
            cmd.op = OP_DEL;
            cidx   = e_r;
          end else if (!dom_r && count_r != NC) begin
            cmd.op = OP_INS;
            cidx   = p_r[IW-1:0];
          end
        end
      end
      S_DEL_L: begin
        if (lrun_r != '0) begin
          cmd.op = OP_DEL;
          cidx   = del_k_r[IW-1:0];
        end
      end
      S_DEL_R: begin
        if (rrun_r != '0) begin
          cmd.op = OP_DEL;
          cidx   = del_k_r[IW-1:0];
        end
      end
      default: ;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      min_mode_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      qv1_r       <= 1'b0;
      qv2_r       <= 1'b0;
      have_best_r <= 1'b0;
      after_r     <= 1'b0;
      have_prev_r <= 1'b0;
      skip_r      <= 1'b0;
      drop_r      <= 1'b0;
      dom_r       <= 1'b0;
      rbroken_r   <= 1'b0;
      lrun_r      <= '0;
      rrun_r      <= '0;
      p_r         <= '0;
      scan_i_r    <= '0;
      drain_r     <= '0;
    end else begin
      if (cfg_we) min_mode_r <= cfg_wdata;
      // the response state loads the output register itself
      if (out_valid_r && !out_stall && state_r != S_RESP) out_valid_r <= 1'b0;

      // query evaluation pipeline
      qv1_r   <= (state_r == S_SCAN) && is_query_r && slot_ok;
      qprod_r <= head.slope * x_r;
      qb1_r   <= head.icpt;
      qv2_r   <= qv1_r;
      qy_r    <= qprod_r[63:0] + 64'(qb1_r);
      if (qv2_r && (!have_best_r || qy_r > best_r)) begin
        best_r      <= qy_r;
        have_best_r <= 1'b1;
      end

      // redundancy results come back in issue order
      if (rres.valid) begin
        unique case (rres.tag)
          TAG_LEFT:  lrun_r <= rres.hit ? lrun_r + 1'b1 : '0;
          TAG_DOM:   dom_r  <= rres.hit;
          TAG_RIGHT: begin
            if (!rbroken_r) begin
              if (rres.hit) rrun_r <= rrun_r + 1'b1;
              else rbroken_r <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            is_query_r   <= in_cmd;
            nline_r.slope <= min_mode_r ? -m_ext : m_ext;
            nline_r.icpt  <= min_mode_r ? -b_ext : b_ext;
            x_r         <= in_query_x;
            p_r         <= '0;
            after_r     <= 1'b0;
            have_prev_r <= 1'b0;
            skip_r      <= 1'b0;
            drop_r      <= 1'b0;
            dom_r       <= 1'b0;
            rbroken_r   <= 1'b0;
            lrun_r      <= '0;
            rrun_r      <= '0;
            have_best_r <= 1'b0;
            scan_i_r    <= '0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (slot_ok && !is_query_r) begin
            if (after_r) begin
              prev_r <= head;
            end else if (lt) begin
              p_r         <= p_r + 1'b1;
              prev_r      <= head;
              have_prev_r <= 1'b1;
            end else if (eq) begin
              // equal slope: the larger intercept wins
              if (head.icpt < nline_r.icpt) begin
                skip_r <= 1'b1;
                e_r    <= scan_i_r;
              end else begin
                drop_r <= 1'b1;
              end
            end else begin
              after_r     <= 1'b1;
              prev_r      <= head;
              have_prev_r <= 1'b1;
            end
          end
          scan_i_r <= scan_i_r + 1'b1;
          if (scan_i_r == LAST) begin
            drain_r <= '0;
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          drain_r <= drain_r + 1'b1;
          if (drain_r == 2'd3) state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          res_value_r <= '0;
          if (is_query_r) begin
            if (count_r == '0) begin
              res_status_r <= ST_EMPTY;
            end else begin
              res_status_r <= ST_OK;
              res_value_r  <= min_mode_r ? -best_r : best_r;
            end
            state_r <= S_RESP;
          end else if (drop_r) begin
            res_status_r <= ST_OK;
            state_r      <= S_RESP;
          end else if (skip_r) begin
            skip_r  <= 1'b0;
            count_r <= count_r - 1'b1;
          end else if (dom_r) begin
            res_status_r <= ST_OK;
            state_r      <= S_RESP;
          end else if (count_r == NC) begin
            res_status_r <= ST_FULL;
            state_r      <= S_RESP;
          end else begin
            count_r <= count_r + 1'b1;
            del_k_r <= p_r - lrun_r;
            state_r <= S_DEL_L;
          end
        end
        S_DEL_L: begin
          if (lrun_r != '0) begin
            lrun_r  <= lrun_r - 1'b1;
            count_r <= count_r - 1'b1;
          end else begin
            // new line now sits at del_k; right side starts after it
            del_k_r <= del_k_r + 1'b1;
            state_r <= S_DEL_R;
          end
        end
        S_DEL_R: begin
          if (rrun_r != '0) begin
            rrun_r  <= rrun_r - 1'b1;
            count_r <= count_r - 1'b1;
          end else begin
            res_status_r <= ST_OK;
            state_r      <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_value_r  <= res_value_r;
            out_status_r <= res_status_r;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule
